// ===== hdl/dwtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dwtq_pkg
// Shared widths, command codes and handoff types of the delayed work timer
// queue.
// ----------------------------------------------------------------------------
package dwtq_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned DELAY_W = 24;

  localparam int unsigned MAX_FIRE   = 16;
  localparam int unsigned FIRE_W     = $clog2(MAX_FIRE + 1);
  localparam int unsigned FIRE_IDX_W = $clog2(MAX_FIRE);

  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef struct packed {
    logic               tick;
    logic [FIRE_W-1:0]  nfired;
    logic               was_pending;
    logic               queue_empty;
    logic [DELAY_W-1:0] next_delay;
  } summary_t;

  typedef struct packed {
    logic                  wr;
    logic [FIRE_IDX_W-1:0] idx;
    logic [ID_W-1:0]       id;
  } fire_wr_t;

endpackage

// ===== hdl/dwtq_if.sv =====
// ----------------------------------------------------------------------------
// dwtq_if
// Valid/ready channels of the timer queue: command words in, result words out.
// ----------------------------------------------------------------------------
interface dwtq_req_if import dwtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ID_W-1:0]    work_id;
  logic [DELAY_W-1:0] delay;

  modport source (output valid, command, work_id, delay, input ready);
  modport sink   (input valid, command, work_id, delay, output ready);
endinterface

interface dwtq_rsp_if import dwtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               fired_valid;
  logic [ID_W-1:0]    fired_id;
  logic               was_pending;
  logic               queue_empty;
  logic [DELAY_W-1:0] next_delay;
  logic               last;

  modport source (output valid, fired_valid, fired_id, was_pending, queue_empty,
                  next_delay, last, input ready);
  modport sink   (input valid, fired_valid, fired_id, was_pending, queue_empty,
                  next_delay, last, output ready);
endinterface

// ===== hdl/dwtq_ram.sv =====
// ----------------------------------------------------------------------------
// dwtq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dwtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dwtq_emit.sv =====
// ----------------------------------------------------------------------------
// dwtq_emit
// Result sequencer: buffers fired slots and plays out the result words of one
// command through an output register.
// ----------------------------------------------------------------------------
module dwtq_emit import dwtq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  summary_t  sum,
  input  fire_wr_t  fire_wr,
  output logic      busy,
  dwtq_rsp_if.source rsp
);

  logic [ID_W-1:0]       fire_buf [MAX_FIRE];
  summary_t              sum_r;
  logic [FIRE_IDX_W-1:0] k;

  logic               out_valid;
  logic               out_fired;
  logic [ID_W-1:0]    out_id;
  logic               out_wp;
  logic               out_empty;
  logic [DELAY_W-1:0] out_delay;
  logic               out_last;

  logic fired;
  logic is_last;
  logic load;

  assign fired   = sum_r.tick && (sum_r.nfired != '0);
  assign is_last = !fired || ((FIRE_W'(k) + FIRE_W'(1)) == sum_r.nfired);
  assign load    = busy && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (fire_wr.wr) begin
      fire_buf[fire_wr.idx] <= fire_wr.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        sum_r <= sum;
        k     <= '0;
      end else if (load) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          k <= k + FIRE_IDX_W'(1);
        end
      end

      if (load) begin
        out_valid <= 1'b1;
        out_fired <= fired;
        out_id    <= fired ? fire_buf[k] : '0;
        out_wp    <= sum_r.tick ? 1'b0 : sum_r.was_pending;
        out_empty <= sum_r.queue_empty;
        out_delay <= sum_r.next_delay;
        out_last  <= is_last;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.fired_valid = out_fired;
  assign rsp.fired_id    = out_id;
  assign rsp.was_pending = out_wp;
  assign rsp.queue_empty = out_empty;
  assign rsp.next_delay  = out_delay;
  assign rsp.last        = out_last;

endmodule

// ===== hdl/delayed_work_timer_queue.sv =====
// ----------------------------------------------------------------------------
// delayed_work_timer_queue
// Software-style delayed work list: slots armed with a deadline, fired in
// arming order on millisecond ticks.
//
// req carries command words (schedule, cancel, query, tick) with a slot
// number and a delay. rsp returns result words; the final word of a command
// has last set. Non-tick commands and ticks with nothing due give one word,
// a tick that fires N slots gives N words in arming order (at most 16).
//
// Each command walks the order list RAM once, one entry per cycle, reading
// the slot's deadline from the target RAM in the following cycle. Once the
// walk is done, the result words go out through the output register. One
// command is in flight at a time; a new command is taken while the last
// result word still waits in the output register.
//
// Reset clears the time counter, the pending marks and the list length; the
// RAMs need no clearing. If rsp stalls, results hold in the output register
// and the next command waits until the last word of the current one has
// reached the output register.
// ----------------------------------------------------------------------------
module delayed_work_timer_queue import dwtq_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  dwtq_req_if.sink   req,
  dwtq_rsp_if.source rsp
);

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SAT_W  = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;
  localparam logic [SAT_W-1:0] DELAY_CAP = SAT_W'((64'd1 << (TIME_BITS - 1)) - 64'd1);
  localparam logic [SAT_W-1:0] OUT_CAP   = SAT_W'(DELAY_MAX);

  typedef enum logic {ST_IDLE, ST_PASS} state_t;

  state_t                state;
  logic [TIME_BITS-1:0]  now;
  logic [NUM_SLOTS-1:0]  pending;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      rd_idx;
  logic [CNT_W-1:0]      wr_idx;
  logic                  s1_valid;
  logic                  s2_valid;
  logic [SLOT_W-1:0]     s2_slot;
  logic [FIRE_W-1:0]     nfired;
  logic [TIME_BITS-1:0]  min_rem;
  cmd_t                  cmd_r;
  logic [SLOT_W-1:0]     id_r;
  logic                  wp_r;

  logic                  accept;
  cmd_t                  req_cmd;
  logic [SLOT_W-1:0]     req_slot;
  logic                  req_ok;
  logic                  req_wp;
  logic                  sched_ok;
  logic [SAT_W-1:0]      delay_w;
  logic [SAT_W-1:0]      delay_sat;

  logic                  issue;
  logic                  pass_done;
  logic                  emit_busy;

  logic                  order_we;
  logic [SLOT_W-1:0]     order_waddr;
  logic [SLOT_W-1:0]     order_wdata;
  logic [SLOT_W-1:0]     order_rdata;
  logic [TIME_BITS-1:0]  target_wdata;
  logic [TIME_BITS-1:0]  target_rdata;

  logic [TIME_BITS-1:0]  diff;
  logic                  due;
  logic [TIME_BITS-1:0]  rem;
  logic                  fire;
  logic                  drop;
  logic                  keep;
  logic [SAT_W-1:0]      min_w;

  summary_t              sum;
  fire_wr_t              fire_wr;

  assign req.ready = (state == ST_IDLE) && !emit_busy;
  assign accept    = req.valid && req.ready;
  assign req_cmd   = cmd_t'(req.command);
  assign req_slot  = SLOT_W'(req.work_id);
  assign req_ok    = 32'(req.work_id) < NUM_SLOTS;
  assign req_wp    = (req_cmd != CMD_TICK) && req_ok && pending[req_slot];
  assign sched_ok  = accept && (req_cmd == CMD_SCHEDULE) && req_ok && !req_wp &&
                     (count < CNT_W'(NUM_SLOTS));
  assign delay_w   = SAT_W'(req.delay);
  assign delay_sat = (delay_w > DELAY_CAP) ? DELAY_CAP : delay_w;

  assign issue     = (state == ST_PASS) && (rd_idx < count);
  assign pass_done = (state == ST_PASS) && !issue && !s1_valid && !s2_valid;

  // deadline test on the entry leaving the walk
  assign diff = target_rdata - now;
  assign due  = diff[TIME_BITS-1] || (diff == '0);
  assign rem  = due ? '0 : diff;
  assign fire = s2_valid && (cmd_r == CMD_TICK) && due && (nfired < FIRE_W'(MAX_FIRE));
  assign drop = fire ||
                (s2_valid && (cmd_r == CMD_CANCEL) && wp_r && (s2_slot == id_r));
  assign keep = s2_valid && !drop;

  assign order_we     = sched_ok || keep;
  assign order_waddr  = sched_ok ? count[SLOT_W-1:0] : wr_idx[SLOT_W-1:0];
  assign order_wdata  = sched_ok ? req_slot : s2_slot;
  assign target_wdata = now + TIME_BITS'(delay_sat);

  assign min_w = SAT_W'(min_rem);

  always_comb begin
    sum.tick        = (cmd_r == CMD_TICK);
    sum.nfired      = nfired;
    sum.was_pending = wp_r;
    sum.queue_empty = (wr_idx == '0);
    if (wr_idx == '0) begin
      sum.next_delay = '0;
    end else if (min_w > OUT_CAP) begin
      sum.next_delay = DELAY_MAX;
    end else begin
      sum.next_delay = DELAY_W'(min_w);
    end
  end

  assign fire_wr.wr  = fire;
  assign fire_wr.idx = nfired[FIRE_IDX_W-1:0];
  assign fire_wr.id  = ID_W'(s2_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      now      <= '0;
      pending  <= '0;
      count    <= '0;
      rd_idx   <= '0;
      wr_idx   <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      nfired   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_r   <= req_cmd;
            id_r    <= req_slot;
            wp_r    <= req_wp;
            rd_idx  <= '0;
            wr_idx  <= '0;
            nfired  <= '0;
            min_rem <= '1;
            if (req_cmd == CMD_TICK) begin
              now <= now + TIME_BITS'(1);
            end
            if (sched_ok) begin
              pending[req_slot] <= 1'b1;
              count             <= count + CNT_W'(1);
            end
            if ((req_cmd == CMD_CANCEL) && req_wp) begin
              pending[req_slot] <= 1'b0;
            end
            state <= ST_PASS;
          end
        end
        ST_PASS: begin
          s1_valid <= issue;
          s2_valid <= s1_valid;
          s2_slot  <= order_rdata;
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (keep) begin
            wr_idx <= wr_idx + CNT_W'(1);
            if (rem < min_rem) begin
              min_rem <= rem;
            end
          end
          if (fire) begin
            nfired           <= nfired + FIRE_W'(1);
            pending[s2_slot] <= 1'b0;
          end
          if (pass_done) begin
            count <= wr_idx;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  dwtq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_SLOTS)
  ) u_order (
    .clk   (clk),
    .we    (order_we),
    .waddr (order_waddr),
    .wdata (order_wdata),
    .raddr (rd_idx[SLOT_W-1:0]),
    .rdata (order_rdata)
  );

  dwtq_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_target (
    .clk   (clk),
    .we    (sched_ok),
    .waddr (req_slot),
    .wdata (target_wdata),
    .raddr (order_rdata),
    .rdata (target_rdata)
  );

  dwtq_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .start   (pass_done),
    .sum     (sum),
    .fire_wr (fire_wr),
    .busy    (emit_busy),
    .rsp     (rsp)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_SLOTS))
    else $error("order list longer than slot count");

  a_pending_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(pending) == int'(count)))
    else $error("pending marks disagree with order list length");

  a_order_hazard: assert property (@(posedge clk) disable iff (rst)
    !(order_we && issue && (order_waddr == rd_idx[SLOT_W-1:0])))
    else $error("order list write overlaps pending read");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    pass_done |=> ((state == ST_IDLE) && emit_busy))
    else $error("result sequencer did not take the command summary");

endmodule
